FILE: src/opr_pkg.sv
// Package for the optimal page replacement simulator.
// Holds sizes, the trace entry and job types, and small encoder functions.
// No dependencies.
package opr_pkg;

    localparam int MAX_TRACE    = 4096;
    localparam int MAX_FRAMES   = 128;
    localparam int PAGE_BITS    = 16;
    localparam int ADDR_W       = $clog2(MAX_TRACE);
    localparam int LEN_W        = $clog2(MAX_TRACE + 1);
    localparam int FRAME_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NF_W         = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W        = 8;
    localparam int CNT_W        = 13;
    localparam int IN_PAGE_W    = 16;
    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    typedef struct packed {
        logic                 wr;
        logic [PAGE_BITS-1:0] page;
    } trace_entry_t;

    localparam int ENTRY_W = $bits(trace_entry_t);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [NF_W-1:0]  nf;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    // Index of the lowest set bit (0 when none is set)
    function automatic logic [FRAME_W-1:0] lowest_set(input logic [MAX_FRAMES-1:0] v);
        logic [FRAME_W-1:0] r;
        r = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = FRAME_W'(k);
            end
        end
        return r;
    endfunction

    // Index of a one-hot vector
    function automatic logic [FRAME_W-1:0] onehot_index(input logic [MAX_FRAMES-1:0] v);
        logic [FRAME_W-1:0] r;
        r = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            if (v[k])
            begin
                r = r | FRAME_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

FILE: src/opr_req_if.sv
// Reference channel: one beat is one trace reference.
// Depends on opr_pkg.
interface opr_req_if;
    logic                           valid;
    logic                           ready;
    logic [opr_pkg::IN_PAGE_W-1:0]  page_id;
    logic                           is_write;
    logic                           is_last;

    modport source (output valid, page_id, is_write, is_last, input ready);
    modport sink   (input valid, page_id, is_write, is_last, output ready);
endinterface

FILE: src/opr_rsp_if.sv
// Result channel: one beat carries both totals of a replay.
// Depends on opr_pkg.
interface opr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [opr_pkg::CNT_W-1:0]  fault_total;
    logic [opr_pkg::CNT_W-1:0]  writeback_total;

    modport source (output valid, fault_total, writeback_total, input ready);
    modport sink   (input valid, fault_total, writeback_total, output ready);
endinterface

FILE: src/opr_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module opr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/opr_queue.sv
// Two-entry job queue between front and back.
// Depends on opr_pkg.
module opr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  opr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output opr_pkg::job_t pop_data
);
    import opr_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign pop_data = slot_reg[rptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && avail)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && avail) ? 1 : 0);
        end
    end
endmodule

FILE: src/opr_front.sv
// Front end: accepts references, stores them in trace memory, holds the
// frame count register and hands a replay job to the back end. Depends on opr_pkg.
module opr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    opr_req_if.sink                     req,
    input  logic                        cfg_write,
    input  logic [opr_pkg::CFG_W-1:0]   cfg_data,
    output logic                        ram_we,
    output logic [opr_pkg::ADDR_W-1:0]  ram_waddr,
    output opr_pkg::trace_entry_t       ram_wdata,
    output logic                        job_push,
    output opr_pkg::job_t               job,
    input  logic                        job_full,
    input  logic                        release_trace
);
    import opr_pkg::*;

    logic [CFG_W-1:0] frames_reg;
    logic [LEN_W-1:0] len_reg;
    logic             busy_reg;
    logic             accept, full;
    logic [LEN_W-1:0] len_after;
    logic [NF_W-1:0]  nf_sat;

    assign req.ready = !busy_reg && !job_full;
    assign accept    = req.valid && req.ready;
    assign full      = (len_reg == LEN_W'(MAX_TRACE));
    assign len_after = full ? len_reg : len_reg + LEN_W'(1);

    // Clamp the frame count to 1..MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            nf_sat = NF_W'(1);
        end
        else if ({1'b0, frames_reg} > (CFG_W + 1)'(MAX_FRAMES))
        begin
            nf_sat = NF_W'(MAX_FRAMES);
        end
        else
        begin
            nf_sat = NF_W'(frames_reg);
        end
    end

    assign ram_we         = accept && !full;
    assign ram_waddr      = len_reg[ADDR_W-1:0];
    assign ram_wdata.wr   = req.is_write;
    assign ram_wdata.page = PAGE_BITS'(req.page_id);
    assign job_push       = accept && req.is_last;
    assign job.len        = len_after;
    assign job.nf         = nf_sat;

    // Count stored beats; hold off input while a replay owns the trace
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
            len_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                frames_reg <= cfg_data;
            end
            if (accept)
            begin
                len_reg <= req.is_last ? '0 : len_after;
            end
            if (job_push)
            begin
                busy_reg <= 1'b1;
            end
            else if (release_trace)
            begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

FILE: src/opr_back.sv
// Back end: replays the stored trace over the frames with optimal victim
// choice and returns the fault and write-back totals. Depends on opr_pkg.
module opr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_avail,
    input  opr_pkg::job_t               job,
    output logic                        job_pop,
    output logic [opr_pkg::ADDR_W-1:0]  ram_raddr,
    input  opr_pkg::trace_entry_t       ram_rdata,
    opr_rsp_if.source                   rsp,
    output logic                        release_trace
);
    import opr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_I, S_GOT_I, S_SC_CHK, S_SC_RD, S_SC_CMP, S_EVICT, S_OUT
    } state_t;

    state_t                state_reg;
    job_t                  job_reg;
    logic [LEN_W-1:0]      i_reg, j_reg;
    trace_entry_t          cur_reg;
    logic [MAX_FRAMES-1:0] valid_reg, dirty_reg, found_reg;
    logic [PAGE_BITS-1:0]  page_reg [MAX_FRAMES];
    logic [FRAME_W-1:0]    last_reg;
    logic [CNT_W-1:0]      fault_reg, wb_reg;
    logic                  out_valid_reg;

    logic [MAX_FRAMES-1:0] use_mask, hit_vec, match_vec, dead_vec, live_open;
    logic [FRAME_W-1:0]    victim;
    logic [LEN_W-1:0]      i_inc;

    // Per-frame compares against the current and the scanned reference
    always_comb
    begin
        for (int f = 0; f < MAX_FRAMES; f++)
        begin
            use_mask[f]  = (32'(f) < 32'(job_reg.nf));
            hit_vec[f]   = valid_reg[f] && use_mask[f] && (page_reg[f] == ram_rdata.page);
            match_vec[f] = hit_vec[f] && !found_reg[f];
        end
    end

    assign live_open = valid_reg & use_mask & ~found_reg;
    assign dead_vec  = use_mask & ~(valid_reg & found_reg);
    assign victim    = (|dead_vec) ? lowest_set(dead_vec) : last_reg;
    assign i_inc     = i_reg + LEN_W'(1);
    assign ram_raddr = (state_reg == S_SC_RD) ? j_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign job_pop   = (state_reg == S_IDLE);

    assign rsp.valid           = out_valid_reg;
    assign rsp.fault_total     = fault_reg;
    assign rsp.writeback_total = wb_reg;

    // Frame pages need no reset; valid bits guard them
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVICT)
        begin
            page_reg[victim] <= cur_reg.page;
        end
        if (state_reg == S_GOT_I)
        begin
            cur_reg <= ram_rdata;
        end
    end

    // Replay sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            found_reg     <= '0;
            last_reg      <= '0;
            fault_reg     <= '0;
            wb_reg        <= '0;
            out_valid_reg <= 1'b0;
            release_trace <= 1'b0;
        end
        else
        begin
            release_trace <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_avail)
                    begin
                        job_reg   <= job;
                        valid_reg <= '0;
                        dirty_reg <= '0;
                        fault_reg <= '0;
                        wb_reg    <= '0;
                        i_reg     <= '0;
                        if (job.len == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD_I;
                        end
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_GOT_I;
                end
                S_GOT_I:
                begin
                    if (|hit_vec)
                    begin
                        if (ram_rdata.wr)
                        begin
                            dirty_reg <= dirty_reg | hit_vec;
                        end
                        i_reg <= i_inc;
                        if (i_inc == job_reg.len)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD_I;
                        end
                    end
                    else
                    begin
                        fault_reg <= sat_inc(fault_reg);
                        found_reg <= '0;
                        j_reg     <= i_inc;
                        state_reg <= S_SC_CHK;
                    end
                end
                S_SC_CHK:
                begin
                    // Stop once every live frame has a next use, or the trace ends
                    if (j_reg == job_reg.len || live_open == '0)
                    begin
                        state_reg <= S_EVICT;
                    end
                    else
                    begin
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_RD:
                begin
                    state_reg <= S_SC_CMP;
                end
                S_SC_CMP:
                begin
                    found_reg <= found_reg | match_vec;
                    if (|match_vec)
                    begin
                        last_reg <= onehot_index(match_vec);
                    end
                    j_reg     <= j_reg + LEN_W'(1);
                    state_reg <= S_SC_CHK;
                end
                S_EVICT:
                begin
                    if (valid_reg[victim] && dirty_reg[victim])
                    begin
                        wb_reg <= sat_inc(wb_reg);
                    end
                    valid_reg[victim] <= 1'b1;
                    dirty_reg[victim] <= cur_reg.wr;
                    i_reg             <= i_inc;
                    if (i_inc == job_reg.len)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RD_I;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        release_trace <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output state");

    a_frames_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((valid_reg & ~use_mask) == '0))
        else $error("frame beyond frame count became valid");

    a_wb_le_fault: assert property (@(posedge clk) disable iff (!rst_n)
        wb_reg <= fault_reg)
        else $error("write-backs exceed faults");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        release_trace |-> $past(out_valid_reg && rsp.ready))
        else $error("trace released without a result beat");
endmodule

FILE: src/optimal_page_replacement_sim.sv
// Top level of the optimal page replacement simulator.
// Depends on opr_pkg, opr_req_if, opr_rsp_if, opr_ram, opr_queue, opr_front, opr_back.
//
// Usage:
//   req carries one trace reference per beat (page_id, is_write, is_last).
//   References are stored one per cycle while req.ready is high; beyond
//   4096 stored entries they are dropped. The beat with is_last starts a
//   replay of the stored trace over the number of frames held in the
//   configuration register (written through cfg_write / cfg_data, reset
//   value 4, 0 acts as 1, values above 128 as 128). rsp carries one beat
//   per trace: fault_total and writeback_total. On a hit a reference is
//   read and checked against the frames; on a miss the trace is scanned
//   ahead, the scan ending when every occupied frame has a next use or the
//   trace ends; the scan through trace memory (one read port) sets the replay time.
//   req.ready is low from the last beat of a trace until its result beat is
//   taken; the result is held in an output register while rsp.ready is low.
//   Reset clears the trace length, the counts and the frame valid bits, and
//   sets the frame count to 4; the trace memory itself is not cleared.
module optimal_page_replacement_sim (
    input  logic                      clk,
    input  logic                      rst_n,
    opr_req_if.sink                   req,
    opr_rsp_if.source                 rsp,
    input  logic                      cfg_write,
    input  logic [opr_pkg::CFG_W-1:0] cfg_data
);
    import opr_pkg::*;

    logic          ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    trace_entry_t  ram_wdata, ram_rdata;
    logic          job_push, job_full, job_pop, job_avail, release_trace;
    job_t          job_in, job_out;

    opr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .job_push      (job_push),
        .job           (job_in),
        .job_full      (job_full),
        .release_trace (release_trace)
    );

    opr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRACE)
    ) u_trace (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    opr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .avail     (job_avail),
        .pop_data  (job_out)
    );

    opr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_avail     (job_avail),
        .job           (job_out),
        .job_pop       (job_pop),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .rsp           (rsp),
        .release_trace (release_trace)
    );
endmodule
